### design/assert_macros.svh
// Assertion helpers used by the top RTL file of the Sobel edge marker.
// Both expect a signal named clk in the scope where they are used; SOBEL_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, held off while reset is asserted.
`define SOBEL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising clock edge, reset cycles included.
`define SOBEL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/sobel_pkg.sv
package sobel_pkg;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int MIN_DIM        = 3;
  localparam int RST_WIDTH      = 1440;
  localparam int RST_HEIGHT     = 810;
  localparam logic [THR_W-1:0] RST_THRESH = 11'd150;

  // One side of a Sobel kernel (1,2,1 weights on 8-bit pixels) peaks at 1020.
  localparam int SUM_W    = 10;
  localparam int GRAD_W   = 10;
  localparam int SQ_W     = 2 * GRAD_W;
  localparam int LIM_W    = THR_W + 1;
  localparam int LIM_SQ_W = 2 * LIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Position flags worked out when a pixel is taken, carried down the pipeline.
  typedef struct packed {
    logic res_valid;  // the pixel reported by this item exists
    logic interior;   // reported pixel has a full 3x3 neighbourhood
    logic last;       // reported pixel closes the frame
    logic top_sel;    // reported pixel is the last column two rows up
  } tag_t;

  // Squared limit for the magnitude test: (threshold + 1) squared.
  function automatic logic [LIM_SQ_W-1:0] lim_square(input logic [THR_W-1:0] thr);
    logic [LIM_W-1:0] lim;
    lim = {1'b0, thr} + LIM_W'(1);
    return LIM_SQ_W'(lim) * LIM_SQ_W'(lim);
  endfunction

endpackage

### design/sobel_ifs.sv
interface sobel_in_if;
  logic                         valid;
  logic                         ready;
  logic [sobel_pkg::PIX_W-1:0]  intensity;
  logic                         flush;

  modport source (output valid, intensity, flush, input ready);
  modport sink   (input valid, intensity, flush, output ready);
endinterface

interface sobel_out_if;
  logic                         valid;
  logic                         ready;
  logic [sobel_pkg::PIX_W-1:0]  pixel_value;
  logic                         marked;
  logic                         is_edge;
  logic                         last_pixel;

  modport source (output valid, pixel_value, marked, is_edge, last_pixel, input ready);
  modport sink   (input valid, pixel_value, marked, is_edge, last_pixel, output ready);
endinterface

interface sobel_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sobel_pkg::CFG_IDX_W-1:0]   index;
  logic [sobel_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/sobel_pos_ctrl.sv
module sobel_pos_ctrl #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT,
  localparam int AW  = $clog2(MAX_WIDTH),
  localparam int WCW = $clog2(MAX_WIDTH + 1),
  localparam int HCW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [sobel_pkg::PIX_W-1:0] intensity,
  input  logic                        flush,
  input  logic [WCW-1:0]              w,
  input  logic [HCW-1:0]              h,
  output logic                        take,
  output logic [AW-1:0]               rd_col,
  output logic [sobel_pkg::PIX_W-1:0] pix,
  output sobel_pkg::tag_t             tag
);

  // Rows run one past the frame while the last row is pushed out.
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int CW1 = AW + 1;

  logic [AW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic           wrap;
  logic [AW-1:0]  cw;
  logic [RW-1:0]  rw;
  logic [CW1-1:0] inc_col;
  logic           in_frame;
  logic           c0;
  logic           ignore;

  always_comb begin
    // A column left at or past a narrowed width moves to the next row first.
    wrap     = WCW'(col_r) >= w;
    cw       = wrap ? '0 : col_r;
    rw       = wrap ? row_r + RW'(1) : row_r;
    in_frame = rw < RW'(h);
    c0       = cw == '0;
    ignore   = flush && in_frame;
    take     = accept && !ignore;
    rd_col   = cw;
    pix      = in_frame ? intensity : '0;
    inc_col  = {1'b0, cw} + CW1'(1);

    tag.res_valid = c0 ? (rw >= RW'(2)) : (rw != '0);
    tag.interior  = (cw >= AW'(2)) && (rw >= RW'(2)) && in_frame;
    tag.last      = c0 && (rw > RW'(h));
    tag.top_sel   = c0;

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (ignore) begin
        col_nxt = cw;
        row_nxt = rw;
      end else if (tag.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (inc_col >= CW1'(w)) begin
        col_nxt = '0;
        row_nxt = rw + RW'(1);
      end else begin
        col_nxt = inc_col[AW-1:0];
        row_nxt = rw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### design/sobel_line_win.sv
module sobel_line_win #(
  parameter int MAX_WIDTH = sobel_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         take,
  input  logic [AW-1:0]                rd_col,
  input  logic [AW-1:0]                top_addr,
  input  logic [sobel_pkg::PIX_W-1:0]  pix,
  input  sobel_pkg::tag_t              tag_in,
  output logic                         c_vld,
  output sobel_pkg::tag_t              c_tag,
  output logic [sobel_pkg::PIX_W-1:0]  c_value,
  output logic [sobel_pkg::GRAD_W-1:0] c_ax,
  output logic [sobel_pkg::GRAD_W-1:0] c_ay
);

  localparam int PW = sobel_pkg::PIX_W;
  localparam int SW = sobel_pkg::SUM_W;

  logic [PW-1:0] upper_mem [MAX_WIDTH];
  logic [PW-1:0] lower_mem [MAX_WIDTH];
  logic [PW-1:0] upper_q_r, lower_q_r, top_q_r;

  logic                 b_vld_r;
  sobel_pkg::tag_t      b_tag_r;
  logic [AW-1:0]        b_col_r;
  logic [PW-1:0]        b_pix_r;

  // Left and middle columns of the window; the right column is the fresh read.
  logic [PW-1:0] win_r [3][2];
  logic [PW-1:0] new_col [3];

  logic                         c_vld_r;
  sobel_pkg::tag_t              c_tag_r;
  logic [PW-1:0]                c_value_r;
  logic [sobel_pkg::GRAD_W-1:0] c_ax_r, c_ay_r;

  logic          fwd;
  logic [SW-1:0] sx_r, sx_l, sy_b, sy_t;
  logic [sobel_pkg::GRAD_W-1:0] ax, ay;
  logic [PW-1:0] value;

  // The end-of-row entry is read while the item in flight may still be writing it.
  assign fwd = b_vld_r && (b_col_r == top_addr);

  always_ff @(posedge clk) begin
    if (adv) begin
      upper_q_r <= upper_mem[rd_col];
      lower_q_r <= lower_mem[rd_col];
      top_q_r   <= fwd ? lower_q_r : upper_mem[top_addr];
      if (b_vld_r) begin
        upper_mem[b_col_r] <= lower_q_r;
        lower_mem[b_col_r] <= b_pix_r;
      end
    end
  end

  always_comb begin
    new_col[0] = upper_q_r;
    new_col[1] = lower_q_r;
    new_col[2] = b_pix_r;

    sx_r = SW'(new_col[0]) + (SW'(new_col[1]) << 1) + SW'(new_col[2]);
    sx_l = SW'(win_r[0][0]) + (SW'(win_r[1][0]) << 1) + SW'(win_r[2][0]);
    sy_b = SW'(win_r[2][0]) + (SW'(win_r[2][1]) << 1) + SW'(new_col[2]);
    sy_t = SW'(win_r[0][0]) + (SW'(win_r[0][1]) << 1) + SW'(new_col[0]);

    ax = (sx_r >= sx_l) ? sx_r - sx_l : sx_l - sx_r;
    ay = (sy_b >= sy_t) ? sy_b - sy_t : sy_t - sy_b;

    value = b_tag_r.top_sel ? top_q_r : win_r[1][1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= take;
      c_vld_r <= b_vld_r && b_tag_r.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= '0;
        win_r[k][1] <= '0;
      end
    end else if (adv && b_vld_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= new_col[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_tag_r   <= tag_in;
      b_col_r   <= rd_col;
      b_pix_r   <= pix;
      c_tag_r   <= b_tag_r;
      c_value_r <= value;
      c_ax_r    <= ax;
      c_ay_r    <= ay;
    end
  end

  assign c_vld   = c_vld_r;
  assign c_tag   = c_tag_r;
  assign c_value = c_value_r;
  assign c_ax    = c_ax_r;
  assign c_ay    = c_ay_r;

endmodule

### design/sobel_mag_test.sv
module sobel_mag_test (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           c_vld,
  input  sobel_pkg::tag_t                c_tag,
  input  logic [sobel_pkg::PIX_W-1:0]    c_value,
  input  logic [sobel_pkg::GRAD_W-1:0]   c_ax,
  input  logic [sobel_pkg::GRAD_W-1:0]   c_ay,
  input  logic [sobel_pkg::LIM_SQ_W-1:0] lim_sq,
  output logic                           d_vld,
  output logic [sobel_pkg::PIX_W-1:0]    d_value,
  output logic                           d_edge,
  output logic                           d_last
);

  localparam int SQW = sobel_pkg::SQ_W;
  localparam int LSW = sobel_pkg::LIM_SQ_W;

  logic                        d_vld_r;
  sobel_pkg::tag_t             d_tag_r;
  logic [sobel_pkg::PIX_W-1:0] d_value_r;
  logic [SQW-1:0]              d_sqx_r, d_sqy_r;
  logic [LSW-1:0]              mag_sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_tag_r   <= c_tag;
      d_value_r <= c_value;
      d_sqx_r   <= SQW'(c_ax) * SQW'(c_ax);
      d_sqy_r   <= SQW'(c_ay) * SQW'(c_ay);
    end
  end

  assign mag_sq  = LSW'(d_sqx_r) + LSW'(d_sqy_r);
  assign d_vld   = d_vld_r;
  assign d_value = d_value_r;
  assign d_edge  = d_tag_r.interior && (mag_sq >= lim_sq);
  assign d_last  = d_tag_r.last;

endmodule

### design/sobel_edge_threshold_marker.sv
// Sobel edge marker: streams 8-bit pixels of one frame in raster order and
// reports, for every pixel, its value, an edge flag and a marked flag.
// in_stream carries intensity and flush; one transaction is one pixel. After
// the frame's pixels, flush transactions pad the stream until the last pixel
// has come out; a flush sent while frame rows are still due is dropped.
// out_stream reports one pixel per transaction, width+1 input positions
// behind, with last_pixel set on the final pixel of the frame.
// cfg_write sets image width, height and edge threshold; it is always ready;
// the user must write it only while no pixel is in flight, which the block does not enforce.
// One pixel is taken every clock cycle while the output does not stall: each
// line store sees one read and one write per pixel, with a second read port on
// the upper store for the end of row. A result passes the b, c and d pipeline
// registers before it reaches the output register.
// Reset clears the counters, window and pipeline and loads 1440 x 810 with a
// threshold of 150; no clearing pass is needed. When the receiver stalls with
// a result waiting, the pipeline holds and in_stream.ready drops.
`include "assert_macros.svh"

module sobel_edge_threshold_marker #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  sobel_in_if.sink   in_stream,
  sobel_out_if.source out_stream,
  sobel_cfg_if.sink  cfg_write
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int HCW = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = sobel_pkg::PIX_W;
  localparam int LSW = sobel_pkg::LIM_SQ_W;

  // Reset dimensions, limited to what the line stores can hold.
  localparam logic [WCW-1:0] W_RST =
    WCW'((sobel_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : sobel_pkg::RST_WIDTH);
  localparam logic [HCW-1:0] H_RST =
    HCW'((sobel_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : sobel_pkg::RST_HEIGHT);

  // Configuration is kept in its clamped form, ready for the datapath.
  logic [WCW-1:0] w_r;
  logic [HCW-1:0] h_r;
  logic [LSW-1:0] lim_sq_r;
  logic [WCW-1:0] w_wr;
  logic [HCW-1:0] h_wr;
  logic [WCW-1:0] w_m1;
  logic           cfg_fire;

  // Pipeline advance: everything moves unless a finished result is held up.
  logic adv;
  logic accept;

  logic                         take;
  logic [AW-1:0]                rd_col;
  logic [PW-1:0]                pix;
  sobel_pkg::tag_t              tag_a;
  logic                         c_vld;
  sobel_pkg::tag_t              c_tag;
  logic [PW-1:0]                c_value;
  logic [sobel_pkg::GRAD_W-1:0] c_ax, c_ay;
  logic                         d_vld;
  logic [PW-1:0]                d_value;
  logic                         d_edge;
  logic                         d_last;

  logic          out_valid_r;
  logic [PW-1:0] out_value_r;
  logic          out_marked_r;
  logic          out_edge_r;
  logic          out_last_r;

  // Widths and heights outside the supported range are pulled to the nearest
  // legal value when they are written.
  always_comb begin
    if (cfg_write.data < sobel_pkg::CFG_DATA_W'(sobel_pkg::MIN_DIM)) begin
      w_wr = WCW'(sobel_pkg::MIN_DIM);
    end else if (32'(cfg_write.data) > 32'(MAX_WIDTH)) begin
      w_wr = WCW'(MAX_WIDTH);
    end else begin
      w_wr = WCW'(cfg_write.data);
    end
    if (cfg_write.data < sobel_pkg::CFG_DATA_W'(sobel_pkg::MIN_DIM)) begin
      h_wr = HCW'(sobel_pkg::MIN_DIM);
    end else if (32'(cfg_write.data) > 32'(MAX_HEIGHT)) begin
      h_wr = HCW'(MAX_HEIGHT);
    end else begin
      h_wr = HCW'(cfg_write.data);
    end
  end

  assign cfg_write.ready = 1'b1;
  assign cfg_fire        = cfg_write.valid && cfg_write.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= W_RST;
      h_r      <= H_RST;
      lim_sq_r <= sobel_pkg::lim_square(sobel_pkg::RST_THRESH);
    end else if (cfg_fire) begin
      unique case (sobel_pkg::cfg_reg_t'(cfg_write.index))
        sobel_pkg::REG_IMAGE_WIDTH:    w_r <= w_wr;
        sobel_pkg::REG_IMAGE_HEIGHT:   h_r <= h_wr;
        sobel_pkg::REG_EDGE_THRESHOLD:
          lim_sq_r <= sobel_pkg::lim_square(cfg_write.data[sobel_pkg::THR_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign w_m1 = w_r - WCW'(1);

  assign adv             = !out_valid_r || out_stream.ready || !d_vld;
  assign in_stream.ready = adv;
  assign accept          = in_stream.valid && adv;

  // Position tracking: column and row counters, flush handling and the
  // classification of the pixel that each transaction releases.
  sobel_pos_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .intensity (in_stream.intensity),
    .flush     (in_stream.flush),
    .w         (w_r),
    .h         (h_r),
    .take      (take),
    .rd_col    (rd_col),
    .pix       (pix),
    .tag       (tag_a)
  );

  // Line stores, 3x3 window and the two gradient magnitudes.
  sobel_line_win #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .take     (take),
    .rd_col   (rd_col),
    .top_addr (w_m1[AW-1:0]),
    .pix      (pix),
    .tag_in   (tag_a),
    .c_vld    (c_vld),
    .c_tag    (c_tag),
    .c_value  (c_value),
    .c_ax     (c_ax),
    .c_ay     (c_ay)
  );

  // Squares of the gradients and the comparison against the squared limit.
  sobel_mag_test u_mag_test (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .c_vld   (c_vld),
    .c_tag   (c_tag),
    .c_value (c_value),
    .c_ax    (c_ax),
    .c_ay    (c_ay),
    .lim_sq  (lim_sq_r),
    .d_vld   (d_vld),
    .d_value (d_value),
    .d_edge  (d_edge),
    .d_last  (d_last)
  );

  // Output register. A pixel with value zero is always marked, as is an edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && d_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_vld) begin
      out_value_r  <= d_value;
      out_marked_r <= d_edge || (d_value == '0);
      out_edge_r   <= d_edge;
      out_last_r   <= d_last;
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.pixel_value = out_value_r;
  assign out_stream.marked      = out_marked_r;
  assign out_stream.is_edge     = out_edge_r;
  assign out_stream.last_pixel  = out_last_r;

  // Reset empties both the last pipeline stage and the output register.
  `SOBEL_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !d_vld, "pipeline not empty after reset")
  // A stalled pipeline must not lose or create a finished result.
  `SOBEL_ASSERT(a_stall_holds, !adv |=> $stable(d_vld), "last stage changed during a stall")
  // A finished result moving on is always caught by the output register.
  `SOBEL_ASSERT(a_result_caught, adv && d_vld |=> out_valid_r, "result dropped at output register")

endmodule

### sim/edge_marker_checker.sv
module edge_marker_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [sobel_pkg::PIX_W-1:0]      in_intensity,
  input  logic                             in_flush,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [sobel_pkg::PIX_W-1:0]      out_pixel_value,
  input  logic                             out_marked,
  input  logic                             out_is_edge,
  input  logic                             out_last_pixel,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               mismatches,
  output int                               outstanding,
  output logic                             frame_open,
  output int                               pixels_checked,
  output int                               edges_seen,
  output int                               frames_closed
);
  import sobel_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             marked;
    logic             is_edge;
    logic             last_pixel;
  } pixel_report_t;

  pixel_report_t         expected_reports[$];
  logic [PIX_W-1:0]      upper_line [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]      lower_line [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]      win [3][3];
  int                    col_pos;
  int                    row_pos;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [THR_W-1:0]      thresh_reg;

  // The line stores are never cleared by reset; zero stands in for old contents.
  initial begin
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
  end

  function automatic int clamp_dim(logic [CFG_DATA_W-1:0] v, int maxv);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic logic gradient_exceeds();
    int gx;
    int gy;
    int lim;
    gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
       - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
    gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
       - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
    lim = int'(thresh_reg) + 1;
    return (gx * gx + gy * gy) >= lim * lim;
  endfunction

  function automatic logic rows_still_due();
    int w;
    int h;
    int r;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    r = (col_pos >= w) ? row_pos + 1 : row_pos;
    return r < h;
  endfunction

  function automatic void step_column(int r, int c, int w);
    col_pos = c + 1;
    row_pos = r;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end
  endfunction

  // Advances the window and line stores by one transaction and queues the
  // report, if any, that it releases.
  function automatic void predict_pixel(logic flush, logic [PIX_W-1:0] intensity);
    int               w;
    int               h;
    int               r;
    int               c;
    int               orow;
    int               ocol;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] top_prev;
    logic             reportable;
    logic             hit;
    pixel_report_t    rep;
    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    r = row_pos;
    c = col_pos;
    if (flush && r < h) return;
    pix = (r < h) ? intensity : '0;
    top_prev = upper_line[w - 1];
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = lower_line[c];
    win[2][2] = pix;
    upper_line[c] = lower_line[c];
    lower_line[c] = pix;
    if (c >= 1) begin
      reportable = r >= 1;
      orow = r - 1;
      ocol = c - 1;
      rep.pixel_value = win[1][1];
    end else begin
      reportable = r >= 2;
      orow = r - 2;
      ocol = w - 1;
      rep.pixel_value = top_prev;
    end
    if (!reportable) begin
      step_column(r, c, w);
      return;
    end
    hit = (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) && gradient_exceeds();
    rep.is_edge = hit;
    rep.marked = hit || (rep.pixel_value == '0);
    rep.last_pixel = (orow + 1 >= h) && (ocol == w - 1);
    expected_reports.push_back(rep);
    if (rep.last_pixel) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      step_column(r, c, w);
    end
  endfunction

  function automatic void note_fault(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : watch
    pixel_report_t seen;
    pixel_report_t want;
    if (!rst_n) begin
      width_reg = CFG_DATA_W'(RST_WIDTH);
      height_reg = CFG_DATA_W'(RST_HEIGHT);
      thresh_reg = RST_THRESH;
      foreach (win[i, j]) win[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      expected_reports.delete();
      mismatches = 0;
      pixels_checked = 0;
      edges_seen = 0;
      frames_closed = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_pixel_value, out_marked, out_is_edge, out_last_pixel};
        if (expected_reports.size() == 0) begin
          note_fault($sformatf("unexpected report: value %0d marked %0b edge %0b last %0b",
                               seen.pixel_value, seen.marked, seen.is_edge, seen.last_pixel));
        end else begin
          want = expected_reports.pop_front();
          pixels_checked++;
          if (seen !== want) begin
            note_fault($sformatf({"report mismatch: expected value %0d marked %0b edge %0b",
                                  " last %0b, got value %0d marked %0b edge %0b last %0b"},
                                 want.pixel_value, want.marked, want.is_edge, want.last_pixel,
                                 seen.pixel_value, seen.marked, seen.is_edge,
                                 seen.last_pixel));
          end else begin
            if (seen.is_edge) edges_seen++;
            if (seen.last_pixel) frames_closed++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:    width_reg = cfg_data;
          REG_IMAGE_HEIGHT:   height_reg = cfg_data;
          REG_EDGE_THRESHOLD: thresh_reg = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_pixel(in_flush, in_intensity);
    end
    outstanding = expected_reports.size();
    frame_open = rows_still_due();
  end

endmodule

### sim/tb_top.sv
// Top of the Sobel edge marker bench. It only generates traffic and gives the
// verdict; all prediction and comparison lives in the checker instance.
module tb_top;
  import sobel_pkg::*;

  // Pixel content patterns. Noise gives strong and weak gradients alike, bars
  // give hard vertical edges, the ramp gives gentle gradients that sit near
  // low thresholds, and the sparse pattern is mostly flat with lone spikes.
  typedef enum logic [1:0] {
    PAT_NOISE,
    PAT_BARS,
    PAT_RAMP,
    PAT_SPARSE
  } pattern_t;

  // How a frame is driven: straight through, broken mid-frame to narrow the
  // width (and perhaps change the height), or broken by a pause only.
  typedef enum logic [1:0] {
    RUN_FULL,
    RUN_NARROWED,
    RUN_PAUSED
  } run_mode_t;

  // Two hand-made 3x3 frames. The first has a vertical step through a centre
  // of 1, so the lone interior pixel is an edge at any threshold below its
  // magnitude of 1020. The second has a strong corner around a centre of 0
  // that no threshold above the largest magnitude can call an edge, so it is
  // marked only for being zero.
  localparam logic [8*9-1:0] STEP_FRAME   = {8'd0,   8'd0,   8'd255,
                                             8'd0,   8'd1,   8'd255,
                                             8'd0,   8'd0,   8'd255};
  localparam logic [8*9-1:0] CORNER_FRAME = {8'd255, 8'd255, 8'd0,
                                             8'd255, 8'd0,   8'd0,
                                             8'd255, 8'd0,   8'd0};

  logic                  clk;
  logic                  rst_n;
  bit                    calm;
  int                    mismatches;
  int                    outstanding;
  logic                  frame_open;
  int                    pixels_checked;
  int                    edges_seen;
  int                    frames_closed;
  int                    items_sent;
  int                    writes_done;
  logic [CFG_DATA_W-1:0] width_shadow;
  logic [CFG_DATA_W-1:0] height_shadow;

  sobel_in_if  in_if ();
  sobel_out_if out_if ();
  sobel_cfg_if cfg_if ();

  sobel_edge_threshold_marker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_write  (cfg_if)
  );

  edge_marker_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_intensity    (in_if.intensity),
    .in_flush        (in_if.flush),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_pixel_value (out_if.pixel_value),
    .out_marked      (out_if.marked),
    .out_is_edge     (out_if.is_edge),
    .out_last_pixel  (out_if.last_pixel),
    .cfg_valid       (cfg_if.valid),
    .cfg_ready       (cfg_if.ready),
    .cfg_index       (cfg_if.index),
    .cfg_data        (cfg_if.data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .frame_open      (frame_open),
    .pixels_checked  (pixels_checked),
    .edges_seen      (edges_seen),
    .frames_closed   (frames_closed)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Safety net: the slowest legitimate run is far shorter than this.
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // The receiver stalls in roughly a third of cycles, except during the calm
  // phase where it takes every report as soon as it is offered.
  always @(negedge clk) begin
    out_if.ready <= calm || ($urandom_range(0, 99) >= 35);
  end

  function automatic int dim_of(logic [CFG_DATA_W-1:0] v, int maxv);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] pixel_for(pattern_t pat, int k);
    case (pat)
      PAT_NOISE: return PIX_W'($urandom_range(0, 255));
      PAT_BARS:  return ((k / 3) % 2 == 1) ? 8'hFF : 8'h00;
      PAT_RAMP:  return PIX_W'(k * 7);
      default:   return ($urandom_range(0, 7) != 0) ? 8'd128 :
                        (($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00);
    endcase
  endfunction

  // Thresholds cluster where decisions are interesting: zero, the values
  // either side of the largest possible magnitude, the everyday low range,
  // and writes with the unused top data bit set, which must be dropped.
  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(1443);
      2:       return CFG_DATA_W'(1441);
      3:       return CFG_DATA_W'($urandom_range(0, 300));
      4:       return CFG_DATA_W'($urandom_range(0, 2047));
      default: return 12'h800 | CFG_DATA_W'($urandom_range(0, 200));
    endcase
  endfunction

  // Offers one transaction on the pixel channel, with random idle cycles in
  // front of it unless the calm phase is running. Starts and ends on a
  // falling edge; valid is left high so back-to-back transactions need no
  // second assignment in one time step.
  task automatic push_item(logic flush, logic [PIX_W-1:0] intensity);
    while (!calm && $urandom_range(0, 99) < 35) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.flush     <= flush;
    in_if.intensity <= intensity;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Register writes happen only with nothing in flight. The valid is
  // dropped at the falling edge that follows the transaction, which keeps
  // consecutive writes apart.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_shadow = value;
    if (idx == REG_IMAGE_HEIGHT) height_shadow = value;
    writes_done++;
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted report has been taken, then
  // lets the pipeline drain of transactions that release no report.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (8) @(negedge clk);
  endtask

  // Sends frame pixels while the checker still expects rows, up to a cap.
  task automatic feed_pixels(pattern_t pat, int cap);
    int k;
    k = 0;
    while (frame_open && k < cap) begin
      push_item(1'b0, pixel_for(pat, k));
      k++;
    end
  endtask

  // Pads past the frame end until the last pixel has been released. Most
  // padding is flush transactions; some are ordinary pixels, whose intensity
  // must be ignored once the frame's rows are complete.
  task automatic close_frame();
    while (!frame_open) begin
      push_item($urandom_range(0, 7) != 0, PIX_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int        target;
    int        phase;
    int        cur_w;
    int        cur_h;
    int        cut;
    pattern_t  pat;
    run_mode_t mode;

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.flush      = 1'b0;
    in_if.intensity  = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_IMAGE_WIDTH;
    cfg_if.data      = '0;
    items_sent       = 0;
    writes_done      = 0;
    width_shadow     = CFG_DATA_W'(RST_WIDTH);
    height_shadow    = CFG_DATA_W'(RST_HEIGHT);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Smallest frame with a zero threshold. A flush sent while the frame
    // still wants rows is dropped, and one ordinary pixel past the frame end
    // only pads.
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'd3);
    write_reg(REG_EDGE_THRESHOLD, '0);
    push_item(1'b1, 8'hA5);
    for (int i = 0; i < 9; i++) push_item(1'b0, STEP_FRAME[8 * (8 - i) +: 8]);
    push_item(1'b0, 8'hFF);
    close_frame();

    // Dimensions below the minimum act as three, and a threshold written as
    // all ones keeps only its low eleven bits, which no magnitude can pass.
    settle();
    write_reg(REG_IMAGE_WIDTH, 12'd1);
    write_reg(REG_IMAGE_HEIGHT, 12'd0);
    write_reg(REG_EDGE_THRESHOLD, 12'hFFF);
    for (int i = 0; i < 9; i++) push_item(1'b0, CORNER_FRAME[8 * (8 - i) +: 8]);
    close_frame();

    // Random frames. Phase 2 opens the widest frame and phase 4 the tallest,
    // both via out-of-range writes that must clamp to the maximum; both are
    // cut short and narrowed so the run stays small. Phase 5 runs without
    // any idle cycles on either side.
    target = items_sent + 700;
    phase = 0;
    while (phase < 6 || items_sent < target) begin
      settle();
      pat  = pattern_t'($urandom_range(0, 3));
      mode = run_mode_t'($urandom_range(0, 2));
      if (phase == 2) begin
        write_reg(REG_IMAGE_WIDTH, 12'hFFF);
        write_reg(REG_IMAGE_HEIGHT, 12'd2);
        mode = RUN_NARROWED;
        pat  = PAT_NOISE;
      end else if (phase == 4) begin
        write_reg(REG_IMAGE_WIDTH, 12'd0);
        write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
        mode = RUN_NARROWED;
      end else begin
        write_reg(REG_IMAGE_WIDTH, ($urandom_range(0, 5) == 0) ?
                  CFG_DATA_W'($urandom_range(0, 2)) : CFG_DATA_W'($urandom_range(3, 24)));
        write_reg(REG_IMAGE_HEIGHT, ($urandom_range(0, 5) == 0) ?
                  CFG_DATA_W'($urandom_range(0, 2)) : CFG_DATA_W'($urandom_range(3, 10)));
      end
      write_reg(REG_EDGE_THRESHOLD, pick_threshold());
      calm <= (phase == 5);

      if (mode == RUN_FULL && $urandom_range(0, 3) == 0) begin
        push_item(1'b1, PIX_W'($urandom_range(0, 255)));
      end
      cur_w = dim_of(width_shadow, DEF_MAX_WIDTH);
      cur_h = dim_of(height_shadow, DEF_MAX_HEIGHT);
      cut = (mode == RUN_FULL) ? cur_w * cur_h :
            $urandom_range(1, (cur_w * cur_h > 200) ? 200 : cur_w * cur_h - 1);
      feed_pixels(pat, cut);

      // A broken frame always drains fully first. Narrowing may push the
      // column counter past the new width, and a lower height may already lie
      // behind the current row, in which case the frame ends at the next last
      // column. The width is never widened mid-frame, as that would read line
      // store entries that were never written. Tall frames always get a new,
      // small height here.
      if (mode != RUN_FULL) begin
        settle();
        if (mode == RUN_NARROWED) begin
          write_reg(REG_IMAGE_WIDTH,
                    CFG_DATA_W'($urandom_range(0, (cur_w > 24) ? 24 : cur_w)));
          if (cur_h > 10 || $urandom_range(0, 1) == 1) begin
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
          end
        end
        feed_pixels(pat, cur_w * (cur_h + 8));
      end
      close_frame();
      phase++;
    end

    settle();
    $display("Checked %0d reported pixels, %0d of them edges, over %0d completed frames.",
             pixels_checked, edges_seen, frames_closed);
    $display("Sent %0d pixel transactions and %0d register writes, sizes 3 to 2048.",
             items_sent, writes_done);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
